@@ rtl/knnfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knnfc_pkg
// Shared types and codes of the nearest-neighbour feature classifier.
// ----------------------------------------------------------------------------
package knnfc_pkg;

   localparam int FEAT_N = 9;
   localparam int FEAT_W = 24;
   localparam int DIST_W = 52;
   localparam int SQ_W   = 50;
   localparam int MAG_W  = 25;

   localparam logic [1:0] CMD_CLEAR    = 2'd0;
   localparam logic [1:0] CMD_APPEND   = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;
   localparam logic [1:0] CMD_SPARE    = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [3:0] K_RESET = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SCAN,
      ST_DRAIN,
      ST_VOTE,
      ST_DONE
   } knnfc_state_type;

endpackage
`default_nettype wire

@@ rtl/knnfc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knnfc_if
// Valid/ready channels of the classifier: request, response and register.
// ----------------------------------------------------------------------------
interface knnfc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [23:0] mid_x;
   logic signed [23:0] mid_y;
   logic signed [23:0] box_width;
   logic signed [23:0] box_height;
   logic signed [23:0] box_angle;
   logic signed [23:0] axis_x;
   logic signed [23:0] axis_y;
   logic signed [23:0] fill_ratio;
   logic signed [23:0] aspect_ratio;
   logic [7:0]         class_in;

   modport source (output valid, cmd, mid_x, mid_y, box_width, box_height,
                   box_angle, axis_x, axis_y, fill_ratio, aspect_ratio, class_in,
                   input ready);
   modport sink (input valid, cmd, mid_x, mid_y, box_width, box_height,
                 box_angle, axis_x, axis_y, fill_ratio, aspect_ratio, class_in,
                 output ready);
endinterface

interface knnfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  class_out;
   logic [3:0]  votes;
   logic [51:0] nearest_distance;

   modport source (output valid, status, class_out, votes, nearest_distance,
                   input ready);
   modport sink (input valid, status, class_out, votes, nearest_distance,
                 output ready);
endinterface

interface knnfc_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/knn_feature_classifier_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knn_feature_classifier_core
// Nearest-neighbour classifier over a store of nine-feature reference entries.
// ----------------------------------------------------------------------------
// A classify streams the stored entries through the single squaring multiplier,
// which sees one feature per cycle.
// One beat is in work at a time; a finished result waits in the output register.
// Synchronous reset empties the store and sets the neighbour count to three.
// ----------------------------------------------------------------------------
module knn_feature_classifier_core #(
   parameter int STORE_DEPTH    = 256,
   parameter int MAX_NEIGHBOURS = 8,
   parameter int CLASS_COUNT    = 256
) (
   input  wire            clock,
   input  wire            reset,
   knnfc_req_if.sink      req,
   knnfc_rsp_if.source    rsp,
   knnfc_csr_if.sink      csr
);
   import knnfc_pkg::*;

   localparam int FDEPTH = STORE_DEPTH * FEAT_N;
   localparam int AW     = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
   localparam int CAW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNTW   = $clog2(STORE_DEPTH + 1);
   localparam int NW     = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
   localparam int KW     = $clog2(MAX_NEIGHBOURS + 1);

   knnfc_state_type state_ff, state_in;

   logic [FEAT_W-1:0] feat_mem [FDEPTH];
   logic [7:0]        class_mem [STORE_DEPTH];

   logic [3:0]        nbr_ff;
   logic [CNTW-1:0]   count_ff;
   logic [AW-1:0]     fill_addr_ff;
   logic [3:0]        wj_ff;
   logic [1:0]        cmd_ff;
   logic [7:0]        cls_ff;
   logic signed [FEAT_W-1:0] q_ff [FEAT_N];
   logic [KW-1:0]     k_ff;

   logic              issue_ff;
   logic [3:0]        rj_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic [CNTW-1:0]   rd_ent_ff;

   logic [FEAT_W-1:0] feat_rd_ff;
   logic [7:0]        class_rd_ff;
   logic              p1v_ff, p1f_ff, p1l_ff;
   logic [3:0]        p1j_ff;
   logic              p2v_ff, p2f_ff, p2l_ff;
   logic [7:0]        p2c_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic              p3v_ff, p3f_ff, p3l_ff;
   logic [7:0]        p3c_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [DIST_W-1:0] acc_ff;
   logic              dv_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [7:0]        dcls_ff;

   logic [MAX_NEIGHBOURS-1:0] bv_ff;
   logic [DIST_W-1:0]         bd_ff [MAX_NEIGHBOURS];
   logic [7:0]                bc_ff [MAX_NEIGHBOURS];

   logic [NW-1:0]     vi_ff;
   logic [KW-1:0]     best_v_ff;
   logic [7:0]        best_c_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [7:0]        rsp_class_ff;
   logic [3:0]        rsp_votes_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   logic              req_fire, rsp_free, start_scan, issue_last, feat_last;
   logic              pipe_empty, vote_end, append_end;
   logic [1:0]        done_status;

   assign req_fire   = req.valid && req.ready;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign feat_last  = (rj_ff == 4'(FEAT_N - 1));
   assign issue_last = issue_ff && feat_last && (rd_ent_ff + CNTW'(1) == count_ff);
   assign pipe_empty = !p1v_ff && !p2v_ff && !p3v_ff && !dv_ff;
   assign vote_end   = (32'(vi_ff) == MAX_NEIGHBOURS - 1);
   assign append_end = (wj_ff == 4'(FEAT_N - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.cmd == CMD_APPEND && 32'(count_ff) < STORE_DEPTH) begin
                  state_in = ST_APPEND;
               end else if (req.cmd == CMD_CLASSIFY && count_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_APPEND: if (append_end) state_in = ST_DONE;
         ST_SCAN:   if (issue_last) state_in = ST_DRAIN;
         ST_DRAIN:  if (pipe_empty) state_in = ST_VOTE;
         ST_VOTE:   if (vote_end) state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req.ready   = 1'b0;
      start_scan  = 1'b0;
      done_status = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            req.ready  = 1'b1;
            start_scan = req_fire && req.cmd == CMD_CLASSIFY && count_ff != '0;
         end
         ST_DONE: begin
            if (cmd_ff == CMD_APPEND && 32'(count_ff) >= STORE_DEPTH &&
                wj_ff != 4'(FEAT_N - 1)) begin
               done_status = STATUS_FULL;
            end else if (cmd_ff == CMD_CLASSIFY && count_ff == '0) begin
               done_status = STATUS_EMPTY;
            end
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   assign csr.ready            = 1'b1;
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_status_ff;
   assign rsp.class_out        = rsp_class_ff;
   assign rsp.votes            = rsp_votes_ff;
   assign rsp.nearest_distance = rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nbr_ff       <= K_RESET;
         count_ff     <= '0;
         fill_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) nbr_ff <= csr.data;
         if (req_fire && req.cmd == CMD_CLEAR) begin
            count_ff     <= '0;
            fill_addr_ff <= '0;
         end
         if (state_ff == ST_APPEND) begin
            fill_addr_ff <= fill_addr_ff + AW'(1);
            if (append_end) count_ff <= count_ff + CNTW'(1);
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Beat capture and append sequencing.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req.cmd;
         wj_ff    <= '0;
         q_ff[0]  <= req.mid_x;
         q_ff[1]  <= req.mid_y;
         q_ff[2]  <= req.box_width;
         q_ff[3]  <= req.box_height;
         q_ff[4]  <= req.box_angle;
         q_ff[5]  <= req.axis_x;
         q_ff[6]  <= req.axis_y;
         q_ff[7]  <= req.fill_ratio;
         q_ff[8]  <= req.aspect_ratio;
         if ({1'b0, req.class_in} < 9'(CLASS_COUNT)) begin
            cls_ff <= req.class_in;
         end else begin
            cls_ff <= 8'(CLASS_COUNT - 1);
         end
         if (nbr_ff == 4'd0) begin
            k_ff <= KW'(1);
         end else if (32'(nbr_ff) > MAX_NEIGHBOURS) begin
            k_ff <= KW'(MAX_NEIGHBOURS);
         end else begin
            k_ff <= KW'(nbr_ff);
         end
      end else if (state_ff == ST_APPEND && !append_end) begin
         wj_ff <= wj_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_APPEND) feat_mem[fill_addr_ff] <= q_ff[wj_ff];
      if (issue_ff) feat_rd_ff <= feat_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_APPEND && wj_ff == 4'd0) class_mem[count_ff[CAW-1:0]] <= cls_ff;
      if (issue_ff && feat_last) class_rd_ff <= class_mem[rd_ent_ff[CAW-1:0]];
   end

   // Read address sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
      end else if (start_scan) begin
         issue_ff <= 1'b1;
      end else if (issue_last) begin
         issue_ff <= 1'b0;
      end
      if (start_scan) begin
         rj_ff      <= '0;
         rd_addr_ff <= '0;
         rd_ent_ff  <= '0;
      end else if (issue_ff) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
         if (feat_last) begin
            rj_ff     <= '0;
            rd_ent_ff <= rd_ent_ff + CNTW'(1);
         end else begin
            rj_ff <= rj_ff + 4'd1;
         end
      end
   end

   // Distance pipeline through the shared squaring multiplier.
   logic signed [FEAT_W:0] diff;
   logic [DIST_W-1:0]      acc_in;

   always_comb begin
      diff   = {q_ff[p1j_ff][FEAT_W-1], q_ff[p1j_ff]} -
               {feat_rd_ff[FEAT_W-1], feat_rd_ff};
      acc_in = (p3f_ff ? '0 : acc_ff) + DIST_W'(sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v_ff <= 1'b0;
         p2v_ff <= 1'b0;
         p3v_ff <= 1'b0;
         dv_ff  <= 1'b0;
      end else begin
         p1v_ff <= issue_ff;
         p2v_ff <= p1v_ff;
         p3v_ff <= p2v_ff;
         dv_ff  <= p3v_ff && p3l_ff;
      end
      p1j_ff <= rj_ff;
      p1f_ff <= (rj_ff == 4'd0);
      p1l_ff <= feat_last;
      p2f_ff <= p1f_ff;
      p2l_ff <= p1l_ff;
      p2c_ff <= class_rd_ff;
      mag_ff <= diff[FEAT_W] ? MAG_W'(-diff) : MAG_W'(diff);
      p3f_ff <= p2f_ff;
      p3l_ff <= p2l_ff;
      p3c_ff <= p2c_ff;
      sq_ff  <= mag_ff * mag_ff;
      if (p3v_ff) acc_ff <= acc_in;
      if (p3v_ff && p3l_ff) begin
         dist_ff <= acc_in;
         dcls_ff <= p3c_ff;
      end
   end

   // Sorted insertion into the k-nearest list.
   logic [MAX_NEIGHBOURS-1:0] lt;

   always_comb begin
      for (int p = 0; p < MAX_NEIGHBOURS; p++) begin
         lt[p] = (p < 32'(k_ff)) && (!bv_ff[p] || dist_ff < bd_ff[p] ||
                 (dist_ff == bd_ff[p] && dcls_ff < bc_ff[p]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start_scan) begin
         bv_ff <= '0;
      end else if (dv_ff) begin
         for (int p = 0; p < MAX_NEIGHBOURS; p++) begin
            if (lt[p]) begin
               if (p > 0 && lt[(p > 0) ? p - 1 : 0]) begin
                  bv_ff[p] <= bv_ff[(p > 0) ? p - 1 : 0];
               end else begin
                  bv_ff[p] <= 1'b1;
               end
            end
         end
      end
      if (dv_ff) begin
         for (int p = 0; p < MAX_NEIGHBOURS; p++) begin
            if (lt[p]) begin
               if (p > 0 && lt[(p > 0) ? p - 1 : 0]) begin
                  bd_ff[p] <= bd_ff[(p > 0) ? p - 1 : 0];
                  bc_ff[p] <= bc_ff[(p > 0) ? p - 1 : 0];
               end else begin
                  bd_ff[p] <= dist_ff;
                  bc_ff[p] <= dcls_ff;
               end
            end
         end
      end
   end

   // Vote count, one candidate per cycle.
   logic [KW-1:0] cnt;

   always_comb begin
      cnt = '0;
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
         if (bv_ff[j] && bc_ff[j] == bc_ff[vi_ff]) cnt = cnt + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff != ST_VOTE) begin
         vi_ff     <= '0;
         if (state_ff != ST_DONE) begin
            best_v_ff <= '0;
            best_c_ff <= '0;
         end
      end else begin
         vi_ff <= vote_end ? vi_ff : vi_ff + NW'(1);
         if (bv_ff[vi_ff] && (cnt > best_v_ff ||
             (cnt == best_v_ff && bc_ff[vi_ff] < best_c_ff))) begin
            best_v_ff <= cnt;
            best_c_ff <= bc_ff[vi_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_status_ff <= done_status;
         if (cmd_ff == CMD_CLASSIFY && count_ff != '0) begin
            rsp_class_ff <= best_c_ff;
            rsp_votes_ff <= 4'(best_v_ff);
            rsp_dist_ff  <= bd_ff[0];
         end else begin
            rsp_class_ff <= '0;
            rsp_votes_ff <= '0;
            rsp_dist_ff  <= '0;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= STORE_DEPTH)
      else $error("entry count beyond store depth");
   a_dist_in_scan: assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance beat outside a scan");
   a_vote_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VOTE) |-> bv_ff[0])
      else $error("vote with an empty neighbour list");
   a_issue_scan: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> state_ff == ST_SCAN)
      else $error("read issued outside a scan");
`endif

endmodule
`default_nettype wire
